// File: rtl/markup_whitespace_normalizer_unit_defines.svh
// Assertion helpers for the whitespace normalizer.
// Both macros sample on clk and are disabled while rst is high.
`ifndef MARKUP_WHITESPACE_NORMALIZER_UNIT_DEFINES_SVH
`define MARKUP_WHITESPACE_NORMALIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MWN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mwn assertion failed");

// Next-cycle implication.
`define MWN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mwn assertion failed");

`else

`define MWN_ASSERT_IMPL(label, ante, cons)
`define MWN_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/mwn_pkg.sv
package mwn_pkg;

  localparam int CNT_W = 6;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // One classified byte: what the back end has to emit for it.
  typedef struct packed {
    logic             join_sp;   // leading join space
    logic [CNT_W-1:0] spaces;    // held spaces to release
    logic             has_byte;  // content byte follows
    logic [7:0]       data;
    logic             fin;       // last byte of the text
    logic             trunc;     // sticky truncation at this point
  } mwn_cmd_t;

endpackage

// File: rtl/mwn_front.sv
module mwn_front #(
  parameter int MAX_WS_RUN = 60
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_final,
  output logic             cmd_push,
  output mwn_pkg::mwn_cmd_t cmd,
  input  logic             cmd_ready
);
  import mwn_pkg::*;

  logic             on_first_line, on_first_line_next;
  logic             line_has_content, line_has_content_next;
  logic             join_pending, join_pending_next;
  logic             after_cr, after_cr_next;
  logic [CNT_W-1:0] held, held_next;
  logic             trunc, trunc_next;

  logic accept, is_lf, is_cr, is_ws, is_crlf, is_content;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;

  // Classify the incoming byte
  assign is_lf      = (in_byte == CH_LF);
  assign is_cr      = (in_byte == CH_CR);
  assign is_ws      = (in_byte == CH_SP) || (in_byte == CH_TAB);
  assign is_crlf    = after_cr && is_lf;
  assign is_content = !is_crlf && !is_lf && !is_cr && !is_ws;

  // Line state update
  always_comb begin
    on_first_line_next    = on_first_line;
    line_has_content_next = line_has_content;
    join_pending_next     = join_pending;
    after_cr_next         = 1'b0;
    held_next             = held;
    trunc_next            = trunc;
    if (is_crlf) begin
      after_cr_next = 1'b0;
    end else if (is_lf || is_cr) begin
      // drop the trailing run of a line that is not the last
      on_first_line_next    = 1'b0;
      line_has_content_next = 1'b0;
      held_next             = '0;
      after_cr_next         = is_cr;
    end else if (is_ws) begin
      if (on_first_line || line_has_content) begin
        if (held < CNT_W'(MAX_WS_RUN)) begin
          held_next = held + 1'b1;
        end else begin
          trunc_next = 1'b1;
        end
      end
    end else begin
      held_next             = '0;
      line_has_content_next = 1'b1;
      join_pending_next     = 1'b1;
    end
  end

  // Build the command for the back end
  always_comb begin
    cmd.join_sp  = is_content && !line_has_content && join_pending;
    cmd.spaces   = is_content ? held : held_next;
    cmd.has_byte = is_content;
    cmd.data     = is_content ? in_byte : 8'h00;
    cmd.fin      = in_final;
    cmd.trunc    = trunc_next;
  end

  assign cmd_push = accept && (is_content || in_final);

  // Hold state; return to the reset values after the final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && in_final)) begin
      on_first_line    <= 1'b1;
      line_has_content <= 1'b0;
      join_pending     <= 1'b0;
      after_cr         <= 1'b0;
      held             <= '0;
      trunc            <= 1'b0;
    end else if (accept) begin
      on_first_line    <= on_first_line_next;
      line_has_content <= line_has_content_next;
      join_pending     <= join_pending_next;
      after_cr         <= after_cr_next;
      held             <= held_next;
      trunc            <= trunc_next;
    end
  end

endmodule

// File: rtl/mwn_queue.sv
`include "markup_whitespace_normalizer_unit_defines.svh"

module mwn_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mwn_pkg::mwn_cmd_t push_cmd,
  output logic              push_ready,
  input  logic              pop,
  output mwn_pkg::mwn_cmd_t head,
  output logic              head_valid
);
  import mwn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  mwn_cmd_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push, do_pop;

  assign push_ready = (fill != FILL_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Store the transfer
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `MWN_ASSERT_IMPL(a_no_overflow, push, push_ready)
  `MWN_ASSERT_NEXT(a_push_fills, push && !pop && push_ready, head_valid)

endmodule

// File: rtl/mwn_back.sv
`include "markup_whitespace_normalizer_unit_defines.svh"

module mwn_back (
  input  logic              clk,
  input  logic              rst,
  input  mwn_pkg::mwn_cmd_t head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              has_byte,
  output logic              run_last,
  output logic              text_end,
  output logic              ws_truncated
);
  import mwn_pkg::*;

  logic     busy;
  mwn_cmd_t cur;
  logic     xfer, last;

  // Select the current result from the working command
  always_comb begin
    priority if (cur.join_sp) begin
      out_byte = CH_SP;
      has_byte = 1'b1;
      last     = (cur.spaces == '0) && !cur.has_byte;
    end else if (cur.spaces != '0) begin
      out_byte = CH_SP;
      has_byte = 1'b1;
      last     = (cur.spaces == CNT_W'(1)) && !cur.has_byte;
    end else begin
      out_byte = cur.has_byte ? cur.data : 8'h00;
      has_byte = cur.has_byte;
      last     = 1'b1;
    end
  end

  assign out_valid    = busy;
  assign run_last     = last;
  assign text_end     = cur.fin && last;
  assign ws_truncated = cur.fin && cur.trunc && last;

  assign xfer = out_valid && out_ready;
  assign pop  = head_valid && (!busy || (xfer && last));

  // Load the next command or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (xfer && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (xfer && !last) begin
      if (cur.join_sp) begin
        cur.join_sp <= 1'b0;
      end else begin
        cur.spaces <= cur.spaces - 1'b1;
      end
    end
  end

  `MWN_ASSERT_IMPL(a_marker_is_end, out_valid && !has_byte, text_end && run_last)
  `MWN_ASSERT_IMPL(a_trunc_on_end, out_valid && ws_truncated, text_end)
  `MWN_ASSERT_NEXT(a_step_keeps_busy, xfer && !last, out_valid)

endmodule

// File: rtl/markup_whitespace_normalizer_unit.sv
// Whitespace normalizer for markup text, one byte in per transfer.
// Input channel: in_valid/in_ready with in_byte and in_final (last byte of
// the text). Output channel: out_valid/out_ready with out_byte, has_byte,
// run_last (last result of one input byte), text_end and ws_truncated.
// A byte that yields nothing and is not final produces no output transfer;
// a final byte always ends with one result flagged text_end, a bare marker
// with has_byte low if nothing else is emitted.
// Input takes one byte per cycle while the command queue has room. Each
// byte that yields output costs one queue slot; the output sequencer then
// sends one result per cycle while out_ready is high; a byte releasing N
// held spaces yields N to N+2 results, and later commands queue meanwhile.
// Each command is stored in a queue slot, then loaded into the sequencer.
// When the receiver stalls, the queue fills and in_ready drops once it holds
// QUEUE_DEPTH commands. Reset empties the queue and returns line state to
// the start of a text; no clearing pass is needed.
module markup_whitespace_normalizer_unit #(
  parameter int MAX_WS_RUN  = 60,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       text_end,
  output logic       ws_truncated
);
  import mwn_pkg::*;

  mwn_cmd_t push_cmd, head;
  logic     push, push_ready, pop, head_valid;

  mwn_front #(
    .MAX_WS_RUN (MAX_WS_RUN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_final  (in_final),
    .cmd_push  (push),
    .cmd       (push_cmd),
    .cmd_ready (push_ready)
  );

  mwn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  mwn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .run_last     (run_last),
    .text_end     (text_end),
    .ws_truncated (ws_truncated)
  );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import mwn_pkg::*;

  localparam int MAX_RUN        = 60;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TARGET_BYTES   = 300;

  // One normalized result as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       tend;
    logic       trunc;
  } norm_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       text_end;
  logic       ws_truncated;

  // Line state of the normalizer as the predictor sees it
  logic       first_line  = 1'b1;
  logic       has_content = 1'b0;
  logic       join_owed   = 1'b0;
  logic       saw_cr      = 1'b0;
  logic [5:0] held_spaces = '0;
  logic       trunc_seen  = 1'b0;

  norm_result_t expected_chars[$];
  logic [7:0]   text_buf[$];
  int           mismatches  = 0;
  int           bytes_sent  = 0;
  int           idle_cycles = 0;
  bit           quiet       = 1'b0;

  markup_whitespace_normalizer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_final     (in_final),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .run_last     (run_last),
    .text_end     (text_end),
    .ws_truncated (ws_truncated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the results that one accepted byte causes and queue them
  task automatic normalize_byte(input logic [7:0] b, input logic fin);
    norm_result_t res[$];
    norm_result_t sp;
    int i;
    sp = '{data: CH_SP, has: 1'b1, last: 1'b0, tend: 1'b0, trunc: 1'b0};
    if (saw_cr && b == CH_LF) begin
      saw_cr = 1'b0;
    end else begin
      saw_cr = 1'b0;
      if (b == CH_LF || b == CH_CR) begin
        // line ends before the last one: drop the trailing run
        first_line  = 1'b0;
        has_content = 1'b0;
        held_spaces = '0;
        saw_cr      = (b == CH_CR);
      end else if (b == CH_SP || b == CH_TAB) begin
        if (first_line || has_content) begin
          if (held_spaces < MAX_RUN) held_spaces++;
          else trunc_seen = 1'b1;
        end
      end else begin
        if (!has_content && join_owed) res.push_back(sp);
        for (i = 0; i < held_spaces; i++) res.push_back(sp);
        held_spaces = '0;
        res.push_back('{data: b, has: 1'b1, last: 1'b0, tend: 1'b0, trunc: 1'b0});
        has_content = 1'b1;
        join_owed   = 1'b1;
      end
    end
    if (fin) begin
      for (i = 0; i < held_spaces; i++) res.push_back(sp);
      if (res.size() == 0) begin
        res.push_back('{data: 8'h00, has: 1'b0, last: 1'b0, tend: 1'b0, trunc: 1'b0});
      end
      res[res.size()-1].tend  = 1'b1;
      res[res.size()-1].trunc = trunc_seen;
      first_line  = 1'b1;
      has_content = 1'b0;
      join_owed   = 1'b0;
      saw_cr      = 1'b0;
      held_spaces = '0;
      trunc_seen  = 1'b0;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_chars.push_back(res[i]);
  endtask

  // Compare one output transfer with the oldest expected result
  task automatic check_result();
    norm_result_t want;
    norm_result_t got;
    got = '{data: out_byte, has: has_byte, last: run_last, tend: text_end,
            trunc: ws_truncated};
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual byte=%02h has=%0d last=%0d",
               $time, got.data, got.has, got.last);
      mismatches++;
    end else begin
      want = expected_chars.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch: expected byte=%02h has=%0d last=%0d end=%0d trunc=%0d",
                 $time, want.data, want.has, want.last, want.tend, want.trunc);
        $display("%0t:           actual   byte=%02h has=%0d last=%0d end=%0d trunc=%0d",
                 $time, got.data, got.has, got.last, got.tend, got.trunc);
        mismatches++;
      end
    end
  endtask

  // Predict on each input transfer, check each output transfer, count idle cycles
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && in_ready) normalize_byte(in_byte, in_final);
      if (out_valid && out_ready) check_result();
    end
  end

  // Stall the output side a random number of cycles before each result
  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_final <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send the buffered text, flagging its last byte as final
  task automatic send_buffer();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Hold off input until every expected result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_content();
    logic [7:0] c;
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(8'h21, 8'h7e));
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR);
    return c;
  endfunction

  task automatic put_run(input int n);
    repeat (n) text_buf.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endtask

  task automatic put_eol();
    case ($urandom_range(0, 2))
      0: text_buf.push_back(CH_LF);
      1: text_buf.push_back(CH_CR);
      default: begin
        text_buf.push_back(CH_CR);
        text_buf.push_back(CH_LF);
      end
    endcase
  endtask

  // Build a well-formed text: lines of words with whitespace around them
  task automatic build_text(input int lines, input bit allow_long);
    int l;
    int w;
    int words;
    text_buf.delete();
    for (l = 0; l < lines; l++) begin
      if (l != 0) put_eol();
      put_run($urandom_range(0, 3));
      words = $urandom_range(0, 3);
      for (w = 0; w < words; w++) begin
        if (w != 0) begin
          if (allow_long && $urandom_range(0, 9) == 0) put_run($urandom_range(55, 64));
          else put_run($urandom_range(1, 3));
        end
        repeat ($urandom_range(1, 4)) text_buf.push_back(pick_content());
      end
      if (allow_long && $urandom_range(0, 15) == 0) put_run($urandom_range(58, 63));
      else put_run($urandom_range(0, 3));
    end
    if ($urandom_range(0, 5) == 0) put_eol();
    if (text_buf.size() == 0) text_buf.push_back(pick_content());
  endtask

  // Extremes, line endings and the short special cases
  task automatic test_directed();
    text_buf = '{8'h41};
    send_buffer();
    text_buf = '{8'h00, 8'hff};
    send_buffer();
    text_buf = '{CH_SP, CH_TAB, 8'h78, CH_SP};
    send_buffer();
    text_buf = '{CH_LF};
    send_buffer();
    text_buf = '{CH_CR, CH_LF};
    send_buffer();
    text_buf = '{8'h61, CH_CR, CH_LF, CH_SP, 8'h62, CH_TAB};
    send_buffer();
    text_buf = '{8'h63, CH_SP, CH_LF, CH_LF, CH_TAB, 8'h64};
    send_buffer();
    text_buf = '{8'h65, CH_CR, CH_CR, 8'h80, CH_LF};
    send_buffer();
    text_buf = '{CH_SP};
    send_buffer();
  endtask

  // Runs at and just above the held maximum, kept and discarded
  task automatic test_run_overflow();
    text_buf.delete();
    text_buf.push_back(8'h61);
    repeat (MAX_RUN) text_buf.push_back(CH_SP);
    text_buf.push_back(8'h62);
    send_buffer();
    text_buf.delete();
    text_buf.push_back(8'h61);
    put_run(MAX_RUN + 2);
    text_buf.push_back(8'h62);
    send_buffer();
    text_buf.delete();
    text_buf.push_back(8'h63);
    repeat (MAX_RUN + 1) text_buf.push_back(CH_TAB);
    text_buf.push_back(CH_LF);
    text_buf.push_back(8'h64);
    send_buffer();
  endtask

  // Back-to-back transfers on both sides
  task automatic test_no_idle();
    quiet = 1'b1;
    repeat (2) begin
      build_text($urandom_range(1, 4), 1'b0);
      send_buffer();
    end
    quiet = 1'b0;
  endtask

  // Let the output side run dry between two texts
  task automatic test_drain_pause();
    build_text(3, 1'b0);
    send_buffer();
    drain();
    build_text(2, 1'b1);
    send_buffer();
  endtask

  // Arbitrary bytes with random text ends
  task automatic test_noise(input int n);
    int i;
    logic [7:0] b;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: b = $urandom_range(0, 1) ? CH_SP : CH_TAB;
        1: b = $urandom_range(0, 1) ? CH_LF : CH_CR;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == n - 1 || $urandom_range(0, 11) == 0);
    end
  endtask

  task automatic test_random_texts();
    while (bytes_sent < TARGET_BYTES) begin
      build_text($urandom_range(1, 5), 1'b1);
      send_buffer();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_run_overflow();
    test_no_idle();
    test_drain_pause();
    test_noise(16);
    test_random_texts();
    test_noise(16);
    drain();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mwn_pkg.sv
rtl/mwn_front.sv
rtl/mwn_queue.sv
rtl/mwn_back.sv
rtl/markup_whitespace_normalizer_unit.sv
tb/sv/tb_top.sv
